[sv/tvdb_pkg.sv]
package tvdb_pkg;

	// Default batch limits and key width.
	localparam int MAX_TRIANGLES_DEF = 16;
	localparam int MAX_VERTICES_DEF  = 24;
	localparam int VERTEX_BITS_DEF   = 64;

	// Fixed field widths of the stream payload.
	localparam int KEY_W = 64;
	localparam int IDX_W = 5;
	localparam int CNT_W = 5;

	// Kind of result that closes one transaction.
	typedef enum logic [1:0] {
		RES_ADD,
		RES_REJECT,
		RES_CLEAR
	} res_kind_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic      start;
		logic      scan_rd;
		logic      write_step;
		logic      load_out;
		res_kind_t kind;
	} tvdb_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_clear;
		logic tri_full;
		logic scan_issued_all;
		logic scan_done;
		logic fits;
		logic last_corner;
	} tvdb_status_t;

endpackage

[sv/tvdb_datapath.sv]
module tvdb_datapath #(
	parameter int MAX_TRIANGLES = tvdb_pkg::MAX_TRIANGLES_DEF,
	parameter int MAX_VERTICES  = tvdb_pkg::MAX_VERTICES_DEF,
	parameter int VERTEX_BITS   = tvdb_pkg::VERTEX_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tvdb_pkg::tvdb_cmd_t        cmd,
	output tvdb_pkg::tvdb_status_t     status,
	input  logic                       in_operation,
	input  logic [tvdb_pkg::KEY_W-1:0] in_key_a,
	input  logic [tvdb_pkg::KEY_W-1:0] in_key_b,
	input  logic [tvdb_pkg::KEY_W-1:0] in_key_c,
	output logic                       accepted,
	output logic [tvdb_pkg::IDX_W-1:0] index_a,
	output logic [tvdb_pkg::IDX_W-1:0] index_b,
	output logic [tvdb_pkg::IDX_W-1:0] index_c,
	output logic [tvdb_pkg::CNT_W-1:0] vertices_held,
	output logic [tvdb_pkg::CNT_W-1:0] triangles_held
);
	import tvdb_pkg::*;

	localparam int AW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int VCW = $clog2(MAX_VERTICES + 1);
	localparam int TCW = $clog2(MAX_TRIANGLES + 1);

	logic [VERTEX_BITS-1:0] table_mem [MAX_VERTICES];
	logic [VERTEX_BITS-1:0] rd_data_s1;
	logic                   rd_valid_s1;
	logic [AW-1:0]          rd_idx_s1;

	logic [VERTEX_BITS-1:0] key_q [3];
	logic                   op_q;
	logic [2:0]             found_q;
	logic [AW-1:0]          idx_q [3];
	logic [VCW-1:0]         ptr_q;
	logic [1:0]             corner_q;
	logic [VCW-1:0]         vcount_q;
	logic [TCW-1:0]         tcount_q;

	logic [1:0]             misses;
	logic [VCW:0]           vsum;
	logic                   wr_miss;

	// Miss count and vertex limit check for the current triangle.
	assign misses  = 2'($countones(~found_q));
	assign vsum    = {1'b0, vcount_q} + (VCW + 1)'(misses);
	assign wr_miss = !found_q[corner_q];

	assign status.is_clear        = op_q;
	assign status.tri_full        = tcount_q >= TCW'(MAX_TRIANGLES);
	assign status.scan_issued_all = ptr_q == vcount_q;
	assign status.scan_done       = (ptr_q == vcount_q) && !rd_valid_s1;
	assign status.fits            = vsum < (VCW + 1)'(MAX_VERTICES);
	assign status.last_corner     = corner_q == 2'd2;

	// Vertex table: one registered read port for the scan, one write port for inserts.
	always_ff @(posedge clk) begin
		if (cmd.scan_rd) begin
			rd_data_s1 <= table_mem[ptr_q[AW-1:0]];
			rd_idx_s1  <= ptr_q[AW-1:0];
		end
		if (cmd.write_step && wr_miss) begin
			table_mem[vcount_q[AW-1:0]] <= key_q[corner_q];
		end
	end

	// Captured keys of the transaction in progress.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			key_q[0] <= in_key_a[VERTEX_BITS-1:0];
			key_q[1] <= in_key_b[VERTEX_BITS-1:0];
			key_q[2] <= in_key_c[VERTEX_BITS-1:0];
		end
	end

	// Scan pointer, compare stage, insert sequencing and batch counts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q        <= 1'b0;
			found_q     <= '0;
			ptr_q       <= '0;
			corner_q    <= '0;
			rd_valid_s1 <= 1'b0;
			vcount_q    <= '0;
			tcount_q    <= '0;
			for (int k = 0; k < 3; k++) begin
				idx_q[k] <= '0;
			end
		end else begin
			rd_valid_s1 <= cmd.scan_rd;
			if (cmd.start) begin
				op_q     <= in_operation;
				found_q  <= '0;
				ptr_q    <= '0;
				corner_q <= '0;
			end
			if (cmd.scan_rd) begin
				ptr_q <= ptr_q + VCW'(1);
			end
			// The lowest matching slot wins, since slots are scanned upward.
			if (rd_valid_s1) begin
				for (int k = 0; k < 3; k++) begin
					if (!found_q[k] && rd_data_s1 == key_q[k]) begin
						found_q[k] <= 1'b1;
						idx_q[k]   <= rd_idx_s1;
					end
				end
			end
			if (cmd.write_step) begin
				corner_q <= corner_q + 2'd1;
				if (wr_miss) begin
					idx_q[corner_q] <= vcount_q[AW-1:0];
					vcount_q        <= vcount_q + VCW'(1);
				end
			end
			if (cmd.load_out) begin
				case (cmd.kind)
					RES_CLEAR: begin
						vcount_q <= '0;
						tcount_q <= '0;
					end
					RES_ADD: begin
						tcount_q <= tcount_q + TCW'(1);
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Result register, loaded when the controller closes the transaction.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			case (cmd.kind)
				RES_CLEAR: begin
					accepted       <= 1'b1;
					index_a        <= '0;
					index_b        <= '0;
					index_c        <= '0;
					vertices_held  <= '0;
					triangles_held <= '0;
				end
				RES_ADD: begin
					accepted       <= 1'b1;
					index_a        <= IDX_W'(idx_q[0]);
					index_b        <= IDX_W'(idx_q[1]);
					index_c        <= IDX_W'(idx_q[2]);
					vertices_held  <= CNT_W'(vcount_q);
					triangles_held <= CNT_W'(tcount_q + TCW'(1));
				end
				default: begin
					accepted       <= 1'b0;
					index_a        <= '0;
					index_b        <= '0;
					index_c        <= '0;
					vertices_held  <= CNT_W'(vcount_q);
					triangles_held <= CNT_W'(tcount_q);
				end
			endcase
		end
	end

	// The vertex limit is never reached, so every insert slot exists.
	a_vcount_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		vcount_q < VCW'(MAX_VERTICES))
		else $error("vertex count reached the vertex limit");

	a_tcount_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		tcount_q <= TCW'(MAX_TRIANGLES))
		else $error("triangle count above the triangle limit");

	// Scan reads only touch slots that hold a vertex.
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_rd |-> ptr_q < vcount_q)
		else $error("scan read beyond the held vertices");

	// An added triangle never follows a full batch.
	a_add_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_out && cmd.kind == RES_ADD) |-> !status.tri_full)
		else $error("triangle added to a full batch");

endmodule

[sv/tvdb_ctrl.sv]
module tvdb_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output tvdb_pkg::tvdb_cmd_t    cmd,
	input  tvdb_pkg::tvdb_status_t status
);
	import tvdb_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CHECK,
		ST_WRITE,
		ST_DONE
	} state_t;

	state_t    state_q;
	res_kind_t kind_q;
	logic      m_tvalid_q;
	logic      out_free;

	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = m_tvalid_q;
	assign out_free = !m_tvalid_q || m_tready;

	// Command decode from the current state.
	always_comb begin
		cmd.start      = (state_q == ST_IDLE) && s_tvalid;
		cmd.scan_rd    = (state_q == ST_SCAN) && !status.is_clear && !status.tri_full &&
		                 !status.scan_issued_all;
		cmd.write_step = state_q == ST_WRITE;
		cmd.load_out   = (state_q == ST_DONE) && out_free;
		cmd.kind       = kind_q;
	end

	// State, result kind and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			kind_q     <= RES_REJECT;
			m_tvalid_q <= 1'b0;
		end else begin
			// The output valid rises on a load and falls when the result is taken.
			if (cmd.load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (status.is_clear) begin
						kind_q  <= RES_CLEAR;
						state_q <= ST_DONE;
					end else if (status.tri_full) begin
						kind_q  <= RES_REJECT;
						state_q <= ST_DONE;
					end else if (status.scan_done) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (status.fits) begin
						state_q <= ST_WRITE;
					end else begin
						kind_q  <= RES_REJECT;
						state_q <= ST_DONE;
					end
				end
				ST_WRITE: begin
					if (status.last_corner) begin
						kind_q  <= RES_ADD;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// A result is only loaded into an output register that is free.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!m_tvalid_q || m_tready))
		else $error("result loaded over a pending result");

	// Each load raises the output valid on the next edge.
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> m_tvalid_q)
		else $error("loaded result not presented");

	// Inserts run only after a scan check has passed.
	a_write_after_check: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE && $past(state_q) != ST_WRITE) |-> $past(status.fits))
		else $error("insert started without room in the batch");

endmodule

[sv/triangle_vertex_dedup_batcher.sv]
// The table is scanned one slot a cycle on a single read port, up to the vertex count held;
// a clear, or an add to a batch at the triangle limit, skips the scan. One transaction is in
// work at a time; the next is accepted the cycle after a result is loaded, even while that
// result waits.
// Reset clears both batch counts and the control state; table contents stay undefined.
module triangle_vertex_dedup_batcher #(
	parameter int MAX_TRIANGLES = tvdb_pkg::MAX_TRIANGLES_DEF,
	parameter int MAX_VERTICES  = tvdb_pkg::MAX_VERTICES_DEF,
	parameter int VERTEX_BITS   = tvdb_pkg::VERTEX_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// s_tdata: vertex_a_key[63:0], vertex_b_key[127:64], vertex_c_key[191:128]
	input  logic [191:0] s_tdata,
	// s_tuser: operation[0]
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// m_tdata: index_a[4:0], index_b[9:5], index_c[14:10], vertices_held[19:15],
	// triangles_held[24:20], zero fill[31:25]
	output logic [31:0]  m_tdata,
	// m_tuser: accepted[0]
	output logic         m_tuser
);
	import tvdb_pkg::*;

	tvdb_cmd_t        cmd;
	tvdb_status_t     status;
	logic [IDX_W-1:0] index_a;
	logic [IDX_W-1:0] index_b;
	logic [IDX_W-1:0] index_c;
	logic [CNT_W-1:0] vertices_held;
	logic [CNT_W-1:0] triangles_held;

	tvdb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.status   (status)
	);

	tvdb_datapath #(
		.MAX_TRIANGLES (MAX_TRIANGLES),
		.MAX_VERTICES  (MAX_VERTICES),
		.VERTEX_BITS   (VERTEX_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.in_operation   (s_tuser),
		.in_key_a       (s_tdata[63:0]),
		.in_key_b       (s_tdata[127:64]),
		.in_key_c       (s_tdata[191:128]),
		.accepted       (m_tuser),
		.index_a        (index_a),
		.index_b        (index_b),
		.index_c        (index_c),
		.vertices_held  (vertices_held),
		.triangles_held (triangles_held)
	);

	// Pack the result fields, lowest field first.
	assign m_tdata = {7'd0, triangles_held, vertices_held, index_c, index_b, index_a};

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
	import tvdb_pkg::*;

	localparam int MAX_TRI   = MAX_TRIANGLES_DEF;
	localparam int MAX_VERT  = MAX_VERTICES_DEF;
	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_CLEAR = 1'b1;
	localparam int RANDOM_ITEMS = 2000;
	localparam int DRAIN_CYCLES = 60;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int LONG_HOLD    = 400;
	localparam logic [KEY_W-1:0] KEY_ZERO = '0;
	localparam logic [KEY_W-1:0] KEY_ONES = '1;

	// One result transaction as it leaves the block.
	typedef struct packed {
		logic             accepted;
		logic [IDX_W-1:0] index_a;
		logic [IDX_W-1:0] index_b;
		logic [IDX_W-1:0] index_c;
		logic [CNT_W-1:0] vertices_held;
		logic [CNT_W-1:0] triangles_held;
	} batch_result_t;

	// Keeps its own copy of the batch and the queue of results still owed.
	class batch_scoreboard;
		logic [KEY_W-1:0] slot_key[MAX_VERT];
		int unsigned      vert_count;
		int unsigned      tri_count;
		batch_result_t    owed_q[$];
		int unsigned      mismatches;

		function new();
			vert_count = 0;
			tri_count  = 0;
			mismatches = 0;
		endfunction

		// Apply one accepted input transaction to the batch and queue its result.
		function void note_input(logic op, logic [KEY_W-1:0] ka, logic [KEY_W-1:0] kb,
				logic [KEY_W-1:0] kc);
			logic [KEY_W-1:0] corner[3];
			int               hit[3];
			int unsigned      misses;
			batch_result_t    r;
			corner[0] = ka;
			corner[1] = kb;
			corner[2] = kc;
			misses = 0;
			r = '0;
			if (op == OP_CLEAR) begin
				vert_count = 0;
				tri_count  = 0;
				r.accepted = 1'b1;
			end else if (tri_count < MAX_TRI) begin
				// All lookups happen before any slot is added.
				for (int j = 0; j < 3; j++) begin
					hit[j] = -1;
					for (int i = 0; i < vert_count; i++)
						if (hit[j] < 0 && slot_key[i] == corner[j])
							hit[j] = i;
					if (hit[j] < 0)
						misses++;
				end
				if (vert_count + misses < MAX_VERT) begin
					int slot[3];
					for (int j = 0; j < 3; j++) begin
						if (hit[j] >= 0) begin
							slot[j] = hit[j];
						end else begin
							slot_key[vert_count] = corner[j];
							slot[j] = vert_count;
							vert_count++;
						end
					end
					tri_count++;
					r.accepted = 1'b1;
					r.index_a  = IDX_W'(slot[0]);
					r.index_b  = IDX_W'(slot[1]);
					r.index_c  = IDX_W'(slot[2]);
				end
			end
			r.vertices_held  = CNT_W'(vert_count);
			r.triangles_held = CNT_W'(tri_count);
			owed_q.push_back(r);
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s mismatch: expected %0d, actual %0d", name, want, got);
				mismatches++;
			end
		endfunction

		// Compare one accepted result transaction with the oldest owed result.
		function void check_result(logic [31:0] data, logic acc);
			batch_result_t want;
			if (owed_q.size() == 0) begin
				$error("result transaction with nothing owed: tdata %h, tuser %b", data, acc);
				mismatches++;
				return;
			end
			want = owed_q.pop_front();
			compare_field("accepted", want.accepted, acc);
			compare_field("index_a", want.index_a, data[4:0]);
			compare_field("index_b", want.index_b, data[9:5]);
			compare_field("index_c", want.index_c, data[14:10]);
			compare_field("vertices_held", want.vertices_held, data[19:15]);
			compare_field("triangles_held", want.triangles_held, data[24:20]);
			compare_field("zero fill", 0, data[31:25]);
		endfunction

		function int unsigned pending();
			return owed_q.size();
		endfunction
	endclass

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [191:0] s_tdata = '0;
	logic         s_tuser = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [31:0]  m_tdata;
	logic         m_tuser;

	batch_scoreboard sb = new();
	bit              calm = 1'b0;
	int unsigned     cycle_count = 0;
	logic [KEY_W-1:0] key_pool[32];
	int unsigned      pool_size = 8;
	int unsigned      fresh_seq = 0;

	triangle_vertex_dedup_batcher dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #10 clk = ~clk;

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Offer one transaction and hold it until the block takes it.
	task automatic send_txn(input logic op, input logic [KEY_W-1:0] ka,
			input logic [KEY_W-1:0] kb, input logic [KEY_W-1:0] kc);
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {kc, kb, ka};
		do @(posedge clk); while (!s_tready);
		sb.note_input(op, ka, kb, kc);
	endtask

	// Random gap after a transaction: mostly none, sometimes short, rarely long.
	task automatic sender_gap();
		int unsigned r;
		int unsigned gap;
		r = $urandom_range(0, 99);
		if (calm || r < 65)
			gap = 0;
		else if (r < 93)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(8, 40);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic add_tri(input logic [KEY_W-1:0] ka, input logic [KEY_W-1:0] kb,
			input logic [KEY_W-1:0] kc);
		send_txn(OP_ADD, ka, kb, kc);
		sender_gap();
	endtask

	task automatic clear_batch();
		send_txn(OP_CLEAR, {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
		sender_gap();
	endtask

	// Stop offering until every owed result has come back.
	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	function automatic logic [KEY_W-1:0] fresh_key();
		fresh_seq++;
		return {32'hC0DE_0000 ^ $urandom, fresh_seq};
	endfunction

	function automatic void refill_pool();
		pool_size = $urandom_range(3, 32);
		for (int i = 0; i < 32; i++)
			key_pool[i] = {$urandom, $urandom};
	endfunction

	// Mostly keys from a small per-batch pool so that hits and duplicates are common.
	function automatic logic [KEY_W-1:0] pick_key();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return {$urandom, $urandom};
		else if (r < 10)
			return (r == 8) ? KEY_ZERO : KEY_ONES;
		else
			return key_pool[$urandom_range(0, pool_size - 1)];
	endfunction

	// Result side: checks every accepted result and applies back-pressure.
	initial begin
		int unsigned stall_left;
		int unsigned seen;
		int unsigned r;
		stall_left = 0;
		seen = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				sb.check_result(m_tdata, m_tuser);
				seen++;
				// One long hold-off so the block fills up and stalls its input.
				if (seen == 500)
					stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (calm) begin
				m_tready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					m_tready <= 1'b1;
				end else begin
					m_tready <= 1'b0;
					stall_left = (r < 96) ? $urandom_range(0, 3) : $urandom_range(10, 40);
				end
			end
		end
	end

	// Input side: directed batch walk, then random batches.
	initial begin
		logic [KEY_W-1:0] k5;
		logic [KEY_W-1:0] k6;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fresh batch with the extreme keys.
		clear_batch();
		add_tri(KEY_ZERO, KEY_ONES, 64'h1);
		// The same key three times misses three times and takes three slots.
		k5 = fresh_key();
		add_tri(k5, k5, k5);
		// All hits: the lowest matching slot is reported.
		add_tri(k5, KEY_ZERO, KEY_ONES);
		repeat (5)
			add_tri(fresh_key(), fresh_key(), fresh_key());
		// 21 vertices held: three more would reach the vertex limit.
		add_tri(fresh_key(), fresh_key(), fresh_key());
		k6 = fresh_key();
		add_tri(k6, KEY_ONES, fresh_key());
		// 23 vertices held: even a single miss is rejected now.
		add_tri(KEY_ZERO, k6, fresh_key());
		// Fill up to the triangle limit with all-hit triangles.
		repeat (7)
			add_tri(k6, k5, KEY_ZERO);
		add_tri(KEY_ONES, KEY_ONES, KEY_ONES);
		add_tri(fresh_key(), k5, k6);
		clear_batch();
		add_tri(k6, k6, KEY_ONES);
		wait_for_drain();

		// Random batches.
		refill_pool();
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 250 == 0)
				calm = ($urandom_range(0, 2) == 0);
			if (n == RANDOM_ITEMS / 2)
				wait_for_drain();
			if ($urandom_range(0, 19) == 0) begin
				if ($urandom_range(0, 1) == 0)
					refill_pool();
				clear_batch();
			end else begin
				add_tri(pick_key(), pick_key(), pick_key());
			end
		end

		// Let every owed result come back, then allow for stray output.
		wait_for_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
